### hw/rtl/nnr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnr_pkg: shared types and constants of the L1 nearest neighbor recommender
// Table sizes, field widths, request codes and the distance saturation helper.
// ----------------------------------------------------------------------------
package nnr_pkg;

    localparam int USER_COUNT  = 16;
    localparam int ITEM_COUNT  = 8;
    localparam int MAX_RESULTS = 8;

    localparam int REQ_W    = 2;
    localparam int USER_W   = 4;
    localparam int ITEM_W   = 3;
    localparam int RATING_W = 3;
    localparam int GENRE_W  = 4;
    localparam int DIST_W   = 6;

    localparam int RATING_MAX = (2 ** RATING_W) - 1;
    localparam int ACC_W      = $clog2(RATING_MAX * ITEM_COUNT + 1);
    localparam int DIST_MAX   = (2 ** DIST_W) - 1;
    localparam int ADDR_W     = USER_W + ITEM_W;
    localparam int MEM_DEPTH  = 2 ** ADDR_W;
    localparam int CNT_W      = $clog2(MAX_RESULTS + 1);

    localparam logic [RATING_W-1:0] THR_RESET = RATING_W'(4);

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_RATING = 2'd0,
        REQ_LOAD_GENRE  = 2'd1,
        REQ_QUERY       = 2'd2
    } t_req;

    // one distance step handed to the shared L1 unit
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              row_end;
        logic [USER_W-1:0] user;
    } t_l1_cmd;

    function automatic logic [DIST_W-1:0] sat_dist(input logic [ACC_W-1:0] a);
        logic [DIST_W-1:0] r;
        if (int'(a) > DIST_MAX) begin
            r = DIST_W'(DIST_MAX);
        end else begin
            r = DIST_W'(a);
        end
        return r;
    endfunction

endpackage

### hw/rtl/nnr_rating_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnr_rating_mem: rating table
// One write and one registered read port; per-entry valid bits make entries
// that were never written read as zero after reset.
// ----------------------------------------------------------------------------
module nnr_rating_mem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [nnr_pkg::ADDR_W-1:0]    i_waddr,
    input  logic [nnr_pkg::RATING_W-1:0]  i_wdata,
    input  logic                          i_re,
    input  logic [nnr_pkg::ADDR_W-1:0]    i_raddr,
    output logic [nnr_pkg::RATING_W-1:0]  o_rdata
);

    logic [nnr_pkg::RATING_W-1:0] r_mem [nnr_pkg::MEM_DEPTH];
    logic [nnr_pkg::MEM_DEPTH-1:0] r_vld;
    logic [nnr_pkg::RATING_W-1:0] r_rdata;
    logic                         r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_vld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule

### hw/rtl/nnr_l1_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnr_l1_unit: shared absolute-difference accumulator
// Adds one |x - y| per cycle of a valid command into a row sum and keeps the least row sum seen
// since the last clear, with the user that produced it.
// ----------------------------------------------------------------------------
module nnr_l1_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  nnr_pkg::t_l1_cmd              i_cmd,
    input  logic [nnr_pkg::RATING_W-1:0]  i_x,
    input  logic [nnr_pkg::RATING_W-1:0]  i_y,
    output logic [nnr_pkg::USER_W-1:0]    o_best_user,
    output logic [nnr_pkg::ACC_W-1:0]     o_best_dist
);

    logic [nnr_pkg::RATING_W-1:0] w_diff;
    logic [nnr_pkg::ACC_W-1:0]    w_sum;
    logic [nnr_pkg::ACC_W-1:0]    r_acc;
    logic [nnr_pkg::ACC_W-1:0]    r_best_dist;
    logic [nnr_pkg::USER_W-1:0]   r_best_user;
    logic                         r_have;

    always_comb begin
        w_diff = (i_x > i_y) ? (i_x - i_y) : (i_y - i_x);
        w_sum  = (i_cmd.first ? '0 : r_acc) + nnr_pkg::ACC_W'(w_diff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_acc       <= '0;
            r_best_dist <= '0;
            r_best_user <= '0;
        end else if (i_clear) begin
            r_have <= 1'b0;
        end else if (i_cmd.valid) begin
            r_acc <= w_sum;
            // strict compare: on a tie the earlier (lower) user stays
            if (i_cmd.row_end && (!r_have || w_sum < r_best_dist)) begin
                r_have      <= 1'b1;
                r_best_dist <= w_sum;
                r_best_user <= i_cmd.user;
            end
        end
    end

    assign o_best_user = r_best_user;
    assign o_best_dist = r_best_dist;

endmodule

### hw/rtl/l1_nearest_neighbor_recommender.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l1_nearest_neighbor_recommender: nearest neighbor item recommender
// Rating table and genre table with load items, and queries that find the
// closest other user by L1 distance and list that user's liked items.
// ----------------------------------------------------------------------------
// Load items are accepted back to back. A query holds the input side not
// ready until its last result is in the output register, longer while the
// output side stalls: the single read port of the rating table is walked
// once for the querying user's row, once for every other user's row through
// one shared absolute-difference unit, and then once per item of the
// neighbor's row to pick the results. Results leave through an output
// register; the last result of a query carries tlast, and tuser is the found
// flag. Write the threshold only while no query is in flight.

module l1_nearest_neighbor_recommender (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] user_index, [6:4] movie_index, [9:7] rating, [13:10] genre_code
    input  logic [15:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] rec_movie, [6:3] neighbor, [12:7] distance
    output logic [15:0] m_axis_tdata,
    // [0] found
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_DIST,
        ST_DRAIN,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_FINAL
    } t_state;

    localparam int UW = nnr_pkg::USER_W;
    localparam int IW = nnr_pkg::ITEM_W;
    localparam int RW = nnr_pkg::RATING_W;

    t_state r_state;

    // input fields
    logic [nnr_pkg::REQ_W-1:0]   w_req;
    logic [UW-1:0]               w_user;
    logic [IW-1:0]               w_movie;
    logic [RW-1:0]               w_rating;
    logic [nnr_pkg::GENRE_W-1:0] w_genre;
    logic                        w_accept;

    // query context
    logic [UW-1:0]               r_q_user;
    logic [IW-1:0]               r_excl;
    logic [nnr_pkg::GENRE_W-1:0] r_genre;
    logic                        r_oor;
    logic [UW:0]                 r_u;
    logic [IW-1:0]               r_i;
    logic [RW-1:0]               r_thr;
    logic [RW-1:0]               r_qrow [nnr_pkg::ITEM_COUNT];
    logic [nnr_pkg::GENRE_W-1:0] r_genre_tab [nnr_pkg::ITEM_COUNT];

    // read tag, registered alongside the table read
    logic          r_tag_v;
    logic          r_tag_row;
    logic [IW-1:0] r_tag_item;
    logic [UW-1:0] r_tag_user;

    // held match and result count
    logic                      r_hold_v;
    logic [IW-1:0]             r_hold_item;
    logic [nnr_pkg::CNT_W-1:0] r_cnt;

    // output register
    logic                      r_out_v;
    logic [IW-1:0]             r_out_rec;
    logic [UW-1:0]             r_out_nb;
    logic [nnr_pkg::DIST_W-1:0] r_out_dist;
    logic                      r_out_found;
    logic                      r_out_last;

    // table and unit hookups
    logic                       w_we;
    logic                       w_re;
    logic [nnr_pkg::ADDR_W-1:0] w_raddr;
    logic [RW-1:0]              w_rdata;
    logic                       w_clear;
    nnr_pkg::t_l1_cmd           w_cmd;
    logic [UW-1:0]              w_best_user;
    logic [nnr_pkg::ACC_W-1:0]  w_best_dist;

    logic                      w_out_free;
    logic [UW:0]               w_u_inc;
    logic [UW:0]               w_u_next;
    logic [UW:0]               w_u_first;
    logic                      w_row_last;
    logic                      w_match;
    logic [nnr_pkg::CNT_W-1:0] w_cnt_next;
    logic                      w_full;

    assign w_req    = s_axis_tuser;
    assign w_user   = s_axis_tdata[3:0];
    assign w_movie  = s_axis_tdata[6:4];
    assign w_rating = s_axis_tdata[9:7];
    assign w_genre  = s_axis_tdata[13:10];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_v || m_axis_tready;

    assign w_we = w_accept && (w_req == nnr_pkg::REQ_LOAD_RATING)
                  && (int'(w_user) < nnr_pkg::USER_COUNT)
                  && (int'(w_movie) < nnr_pkg::ITEM_COUNT);
    assign w_clear = w_accept && (w_req == nnr_pkg::REQ_QUERY);

    assign w_row_last = (r_i == IW'(nnr_pkg::ITEM_COUNT - 1));

    // skip the querying user while walking the others
    always_comb begin
        w_u_first = (r_q_user == '0) ? (UW+1)'(1) : '0;
        w_u_inc   = r_u + (UW+1)'(1);
        w_u_next  = (w_u_inc == {1'b0, r_q_user}) ? (w_u_inc + (UW+1)'(1)) : w_u_inc;
    end

    always_comb begin
        w_re    = 1'b0;
        w_raddr = {r_q_user, r_i};
        case (r_state)
            ST_ROW: begin
                w_re    = 1'b1;
                w_raddr = {r_q_user, r_i};
            end
            ST_DIST: begin
                w_re    = 1'b1;
                w_raddr = {r_u[UW-1:0], r_i};
            end
            ST_SCAN_RD: begin
                w_re    = 1'b1;
                w_raddr = {w_best_user, r_i};
            end
            default: begin
                w_re = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_cmd.valid   = r_tag_v && !r_tag_row;
        w_cmd.first   = (r_tag_item == '0);
        w_cmd.row_end = (r_tag_item == IW'(nnr_pkg::ITEM_COUNT - 1));
        w_cmd.user    = r_tag_user;
    end

    assign w_match = (w_rdata >= r_thr) && (r_genre_tab[r_i] == r_genre)
                     && (r_i != r_excl);
    assign w_cnt_next = r_cnt + nnr_pkg::CNT_W'(1);
    assign w_full     = (w_cnt_next == nnr_pkg::CNT_W'(nnr_pkg::MAX_RESULTS));

    nnr_rating_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr ({w_user, w_movie}),
        .i_wdata (w_rating),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    nnr_l1_unit u_l1 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (w_clear),
        .i_cmd       (w_cmd),
        .i_x         (r_qrow[r_tag_item]),
        .i_y         (w_rdata),
        .o_best_user (w_best_user),
        .o_best_dist (w_best_dist)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_thr       <= nnr_pkg::THR_RESET;
            r_tag_v     <= 1'b0;
            r_tag_row   <= 1'b0;
            r_tag_item  <= '0;
            r_tag_user  <= '0;
            r_hold_v    <= 1'b0;
            r_hold_item <= '0;
            r_cnt       <= '0;
            r_out_v     <= 1'b0;
            r_out_rec   <= '0;
            r_out_nb    <= '0;
            r_out_dist  <= '0;
            r_out_found <= 1'b0;
            r_out_last  <= 1'b0;
            r_q_user    <= '0;
            r_excl      <= '0;
            r_genre     <= '0;
            r_oor       <= 1'b0;
            r_u         <= '0;
            r_i         <= '0;
            for (int k = 0; k < nnr_pkg::ITEM_COUNT; k++) begin
                r_genre_tab[k] <= '0;
                r_qrow[k]      <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end

            r_tag_v <= 1'b0;
            if (r_tag_v && r_tag_row) begin
                r_qrow[r_tag_item] <= w_rdata;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        case (w_req)
                            nnr_pkg::REQ_LOAD_GENRE: begin
                                if (int'(w_movie) < nnr_pkg::ITEM_COUNT) begin
                                    r_genre_tab[w_movie] <= w_genre;
                                end
                            end
                            nnr_pkg::REQ_QUERY: begin
                                r_q_user <= w_user;
                                r_excl   <= w_movie;
                                r_genre  <= w_genre;
                                r_i      <= '0;
                                r_hold_v <= 1'b0;
                                r_cnt    <= '0;
                                if (int'(w_user) < nnr_pkg::USER_COUNT) begin
                                    r_oor   <= 1'b0;
                                    r_state <= ST_ROW;
                                end else begin
                                    r_oor   <= 1'b1;
                                    r_state <= ST_FINAL;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_ROW: begin
                    r_tag_v    <= 1'b1;
                    r_tag_row  <= 1'b1;
                    r_tag_item <= r_i;
                    if (w_row_last) begin
                        r_i     <= '0;
                        r_u     <= w_u_first;
                        r_state <= ST_DIST;
                    end else begin
                        r_i <= r_i + IW'(1);
                    end
                end
                ST_DIST: begin
                    r_tag_v    <= 1'b1;
                    r_tag_row  <= 1'b0;
                    r_tag_item <= r_i;
                    r_tag_user <= r_u[UW-1:0];
                    if (w_row_last) begin
                        r_i <= '0;
                        r_u <= w_u_next;
                        if (int'(w_u_next) >= nnr_pkg::USER_COUNT) begin
                            r_state <= ST_DRAIN;
                        end
                    end else begin
                        r_i <= r_i + IW'(1);
                    end
                end
                ST_DRAIN: begin
                    // last row sum lands in the unit this cycle
                    r_i     <= '0;
                    r_state <= ST_SCAN_RD;
                end
                ST_SCAN_RD: begin
                    r_state <= ST_SCAN_EV;
                end
                ST_SCAN_EV: begin
                    if (!(w_match && r_hold_v && !w_out_free)) begin
                        if (w_match) begin
                            if (r_hold_v) begin
                                r_out_v     <= 1'b1;
                                r_out_rec   <= r_hold_item;
                                r_out_nb    <= w_best_user;
                                r_out_dist  <= nnr_pkg::sat_dist(w_best_dist);
                                r_out_found <= 1'b1;
                                r_out_last  <= 1'b0;
                            end
                            r_hold_v    <= 1'b1;
                            r_hold_item <= r_i;
                            r_cnt       <= w_cnt_next;
                        end
                        if (w_row_last || (w_match && w_full)) begin
                            r_state <= ST_FINAL;
                        end else begin
                            r_i     <= r_i + IW'(1);
                            r_state <= ST_SCAN_RD;
                        end
                    end
                end
                ST_FINAL: begin
                    if (w_out_free) begin
                        r_out_v    <= 1'b1;
                        r_out_last <= 1'b1;
                        if (r_oor) begin
                            r_out_rec   <= '0;
                            r_out_nb    <= '0;
                            r_out_dist  <= '0;
                            r_out_found <= 1'b0;
                        end else begin
                            r_out_rec   <= r_hold_v ? r_hold_item : '0;
                            r_out_nb    <= w_best_user;
                            r_out_dist  <= nnr_pkg::sat_dist(w_best_dist);
                            r_out_found <= r_hold_v;
                        end
                        r_hold_v <= 1'b0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = r_out_v;
    assign m_axis_tdata    = {3'b000, r_out_dist, r_out_nb, r_out_rec};
    assign m_axis_tuser[0] = r_out_found;
    assign m_axis_tlast    = r_out_last;

endmodule

### tb/sv/l1_nearest_neighbor_recommender_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l1_nearest_neighbor_recommender_tb: self-checking bench of the recommender
// Loads ratings and genres, issues queries under several thresholds, and checks
// every result against an in-bench model of the rating and genre tables, with
// bursty input, stalling output and one long output hold-off.
// ----------------------------------------------------------------------------
module l1_nearest_neighbor_recommender_tb;

    localparam logic [nnr_pkg::REQ_W-1:0] REQ_RESERVED = 2'd3;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 900;

    typedef struct packed {
        logic [nnr_pkg::ITEM_W-1:0] rec_movie;
        logic [nnr_pkg::USER_W-1:0] neighbor;
        logic [nnr_pkg::DIST_W-1:0] distance;
        logic                       found;
        logic                       last;
    } t_rec;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_wdata = '0;

    // model of the block's tables
    logic [nnr_pkg::RATING_W-1:0] rating_tbl [nnr_pkg::USER_COUNT][nnr_pkg::ITEM_COUNT];
    logic [nnr_pkg::GENRE_W-1:0]  genre_tbl [nnr_pkg::ITEM_COUNT];
    logic [nnr_pkg::RATING_W-1:0] like_thr;
    t_rec                         pending_recs[$];
    int                           fail_count = 0;

    int       burst_left = 0;
    int       max_gap = 0;
    t_rx_mode rx_mode = RX_ALWAYS;
    int       rx_phase = 0;
    int       hold_request = 0;
    int       hold_left = 0;

    l1_nearest_neighbor_recommender uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

    // Update the tables for a load, or queue the results a query must give.
    function automatic void predict_item(input logic [nnr_pkg::REQ_W-1:0] kind,
                                         input logic [nnr_pkg::USER_W-1:0] user,
                                         input logic [nnr_pkg::ITEM_W-1:0] movie,
                                         input logic [nnr_pkg::RATING_W-1:0] rating,
                                         input logic [nnr_pkg::GENRE_W-1:0] genre);
        int   best;
        int   best_d;
        int   d;
        int   x;
        int   y;
        int   n;
        bit   have;
        t_rec hits [nnr_pkg::MAX_RESULTS];
        t_rec r;
        if (kind == nnr_pkg::REQ_LOAD_RATING) begin
            rating_tbl[user][movie] = rating;
        end else if (kind == nnr_pkg::REQ_LOAD_GENRE) begin
            genre_tbl[movie] = genre;
        end else if (kind == nnr_pkg::REQ_QUERY) begin
            have = 1'b0;
            best = 0;
            best_d = 0;
            for (int u = 0; u < nnr_pkg::USER_COUNT; u++) begin
                if (u != int'(user)) begin
                    d = 0;
                    for (int i = 0; i < nnr_pkg::ITEM_COUNT; i++) begin
                        x = rating_tbl[user][i];
                        y = rating_tbl[u][i];
                        d += (x > y) ? (x - y) : (y - x);
                    end
                    if (!have || d < best_d) begin
                        have = 1'b1;
                        best = u;
                        best_d = d;
                    end
                end
            end
            r = '0;
            r.last = 1'b1;
            if (!have) begin
                pending_recs.push_back(r);
            end else begin
                r.neighbor = nnr_pkg::USER_W'(best);
                r.distance = (best_d > nnr_pkg::DIST_MAX) ?
                             nnr_pkg::DIST_W'(nnr_pkg::DIST_MAX) :
                             nnr_pkg::DIST_W'(best_d);
                n = 0;
                for (int i = 0; i < nnr_pkg::ITEM_COUNT; i++) begin
                    if (n < nnr_pkg::MAX_RESULTS && rating_tbl[best][i] >= like_thr &&
                        genre_tbl[i] == genre && i != int'(movie)) begin
                        hits[n] = r;
                        hits[n].rec_movie = nnr_pkg::ITEM_W'(i);
                        hits[n].found = 1'b1;
                        n++;
                    end
                end
                if (n == 0) begin
                    pending_recs.push_back(r);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        hits[i].last = (i == n - 1);
                        pending_recs.push_back(hits[i]);
                    end
                end
            end
        end
    endfunction

    // Offer one item, with a random gap at the start of each burst.
    task automatic send_item(input logic [nnr_pkg::REQ_W-1:0] kind,
                             input logic [nnr_pkg::USER_W-1:0] user,
                             input logic [nnr_pkg::ITEM_W-1:0] movie,
                             input logic [nnr_pkg::RATING_W-1:0] rating,
                             input logic [nnr_pkg::GENRE_W-1:0] genre);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, max_gap);
            burst_left = $urandom_range(1, 8);
        end else begin
            gap = 0;
        end
        burst_left--;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, genre, rating, movie, user};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_item(kind, user, movie, rating, genre);
    endtask

    task automatic send_random_item();
        int                           pick;
        logic [nnr_pkg::REQ_W-1:0]    kind;
        logic [nnr_pkg::GENRE_W-1:0]  genre;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            kind = nnr_pkg::REQ_LOAD_RATING;
        end else if (pick < 60) begin
            kind = nnr_pkg::REQ_LOAD_GENRE;
        end else if (pick < 95) begin
            kind = nnr_pkg::REQ_QUERY;
        end else begin
            kind = REQ_RESERVED;
        end
        // keep most genres in a narrow set so queries find matches
        if ($urandom_range(0, 9) < 8) begin
            genre = nnr_pkg::GENRE_W'($urandom_range(0, 2));
        end else begin
            genre = nnr_pkg::GENRE_W'($urandom);
        end
        send_item(kind, nnr_pkg::USER_W'($urandom), nnr_pkg::ITEM_W'($urandom),
                  nnr_pkg::RATING_W'($urandom), genre);
    endtask

    // Stop offering, wait for every result, then let the block settle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_recs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [nnr_pkg::RATING_W-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        like_thr = value;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_item(nnr_pkg::REQ_QUERY, 4'd0, 3'd0, 3'd0, 4'd0);
        send_item(nnr_pkg::REQ_QUERY, 4'd15, 3'd7, 3'd7, 4'd0);
        set_threshold(3'd0);
        // every item matches except the excluded one
        send_item(nnr_pkg::REQ_QUERY, 4'd0, 3'd3, 3'd0, 4'd0);
    endtask

    task automatic test_directed();
        set_threshold(3'd7);
        max_gap = 3;
        for (int i = 0; i < nnr_pkg::ITEM_COUNT; i++) begin
            send_item(nnr_pkg::REQ_LOAD_RATING, 4'd15, nnr_pkg::ITEM_W'(i), 3'd7, 4'd0);
        end
        send_item(nnr_pkg::REQ_LOAD_RATING, 4'd14, 3'd7, 3'd7, 4'd15);
        send_item(nnr_pkg::REQ_LOAD_RATING, 4'd14, 3'd2, 3'd7, 4'd0);
        send_item(nnr_pkg::REQ_LOAD_GENRE, 4'd15, 3'd7, 3'd7, 4'd15);
        send_item(nnr_pkg::REQ_LOAD_GENRE, 4'd0, 3'd2, 3'd0, 4'd15);
        send_item(nnr_pkg::REQ_QUERY, 4'd15, 3'd2, 3'd7, 4'd15);
        send_item(nnr_pkg::REQ_QUERY, 4'd15, 3'd7, 3'd0, 4'd15);
        send_item(nnr_pkg::REQ_QUERY, 4'd15, 3'd0, 3'd0, 4'd9);
        // reserved request type: dropped without a result
        send_item(REQ_RESERVED, 4'd15, 3'd7, 3'd7, 4'd15);
        send_item(nnr_pkg::REQ_QUERY, 4'd14, 3'd0, 3'd0, 4'd15);
        send_item(nnr_pkg::REQ_QUERY, 4'd0, 3'd0, 3'd0, 4'd0);
    endtask

    task automatic test_random_phases();
        logic [nnr_pkg::RATING_W-1:0] thr_list [4];
        thr_list[0] = 3'd3;
        thr_list[1] = 3'd0;
        thr_list[2] = 3'd7;
        thr_list[3] = nnr_pkg::RATING_W'($urandom);
        for (int p = 0; p < 4; p++) begin
            set_threshold(thr_list[p]);
            max_gap = (p == 1) ? 0 : 2 + 3 * p;
            rx_mode = t_rx_mode'(p % 3);
            repeat (30) send_random_item();
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        rx_mode = RX_ALWAYS;
        max_gap = 0;
        hold_request = HOLD_CYCLES;
        for (int k = 0; k < 12; k++) begin
            if (k % 2 == 0) begin
                send_item(nnr_pkg::REQ_QUERY, nnr_pkg::USER_W'($urandom),
                          nnr_pkg::ITEM_W'($urandom), nnr_pkg::RATING_W'($urandom),
                          nnr_pkg::GENRE_W'($urandom_range(0, 1)));
            end else begin
                send_random_item();
            end
        end
        rx_mode = RX_RANDOM;
    endtask

    initial begin
        for (int u = 0; u < nnr_pkg::USER_COUNT; u++) begin
            for (int i = 0; i < nnr_pkg::ITEM_COUNT; i++) begin
                rating_tbl[u][i] = '0;
            end
        end
        for (int i = 0; i < nnr_pkg::ITEM_COUNT; i++) begin
            genre_tbl[i] = '0;
        end
        like_thr = nnr_pkg::THR_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed();
        test_random_phases();
        test_backpressure();

        wait_idle();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Output ready: a long hold-off on request, otherwise the current pattern.
    always @(posedge i_clk) begin
        rx_phase <= (rx_phase + 1) % 7;
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: begin
                    m_axis_tready <= 1'b1;
                end
                RX_RANDOM: begin
                    m_axis_tready <= ($urandom_range(0, 9) < 7);
                end
                default: begin
                    m_axis_tready <= (rx_phase != 0 && rx_phase != 3 && rx_phase != 4);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        t_rec got;
        t_rec want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.rec_movie = m_axis_tdata[2:0];
            got.neighbor  = m_axis_tdata[6:3];
            got.distance  = m_axis_tdata[12:7];
            got.found     = m_axis_tuser[0];
            got.last      = m_axis_tlast;
            if (pending_recs.size() == 0) begin
                $error("result with none expected: tdata %h found %b last %b",
                       m_axis_tdata, got.found, got.last);
                fail_count++;
            end else begin
                want = pending_recs.pop_front();
                if (got.rec_movie !== want.rec_movie) begin
                    $error("rec_movie: expected %0d, got %0d", want.rec_movie, got.rec_movie);
                    fail_count++;
                end
                if (got.neighbor !== want.neighbor) begin
                    $error("neighbor: expected %0d, got %0d", want.neighbor, got.neighbor);
                    fail_count++;
                end
                if (got.distance !== want.distance) begin
                    $error("distance: expected %0d, got %0d", want.distance, got.distance);
                    fail_count++;
                end
                if (got.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, got.found);
                    fail_count++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

endmodule
